// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the range tree.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define RARMT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be seen outside reset
`define RARMT_NEVER(name, clk, rst, cond, msg) \
   `RARMT_ASSERT(name, clk, rst, !(cond), msg)

`endif

// File: rtl/core/rarmt_pkg.sv
// ----------------------------------------------------------------------------
// rarmt_pkg
// Types and constants shared by the range add / range minimum tree.
// ----------------------------------------------------------------------------
package rarmt_pkg;

   localparam int unsigned MAX_ELEMENTS = 1024;
   localparam int unsigned INDEX_W      = 10;
   localparam int unsigned COUNT_W      = 11;
   localparam int unsigned NODE_W       = 11;
   localparam int unsigned ROW_W        = 10;
   localparam int unsigned DEPTH_W      = 4;
   localparam int unsigned STACK_DEPTH  = 10;
   localparam int unsigned DATA_W       = 32;

   localparam logic [31:0] EMPTY_MINIMUM = 32'd2100000000;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_ADD   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic               REG_ELEMENT_COUNT = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_VISIT,
      ST_EVAL,
      ST_CHILD,
      ST_DECIDE,
      ST_RETURN,
      ST_COMB_RD,
      ST_COMB_WR,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic start;
      logic issue_read;
      logic eval;
      logic child_write;
      logic descend;
      logic ret_sibling;
      logic ret_pop;
      logic comb_read;
      logic comb_write;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic live;
      logic is_query;
      logic disjoint;
      logic covered;
      logic internal;
      logic is_left;
      logic at_root;
      logic rsp_busy;
   } status_type;

endpackage

// File: rtl/core/rarmt_datapath.sv
// ----------------------------------------------------------------------------
// rarmt_datapath
// Node stores, traversal registers, node arithmetic and result register.
// ----------------------------------------------------------------------------
module rarmt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  rarmt_pkg::cmd_type                  cmd,
   output rarmt_pkg::status_type               status,
   input  logic [rarmt_pkg::COUNT_W-1:0]       element_count,
   input  logic [1:0]                          req_mode,
   input  logic [rarmt_pkg::INDEX_W-1:0]       req_lo_index,
   input  logic [rarmt_pkg::INDEX_W-1:0]       req_hi_index,
   input  logic signed [31:0]                  req_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic signed [31:0]                  rsp_range_minimum
);

   localparam int unsigned IW = rarmt_pkg::INDEX_W;

   // each row holds a sibling pair: node 2r in the low half, 2r+1 in the high
   logic [63:0] min_mem  [0:(1<<rarmt_pkg::ROW_W)-1];
   logic [63:0] pend_mem [0:(1<<rarmt_pkg::ROW_W)-1];

   logic [63:0] min_rd_a_ff, min_rd_b_ff, pend_rd_a_ff, pend_rd_b_ff;

   logic [1:0]    mode_ff;
   logic [IW-1:0] i_ff, j_ff, nm1_ff, a_ff, b_ff;
   logic [31:0]   value_ff;
   logic [rarmt_pkg::NODE_W-1:0]  node_ff;
   logic [rarmt_pkg::DEPTH_W-1:0] depth_ff;
   logic [IW-1:0] stack_a_ff [0:rarmt_pkg::STACK_DEPTH-1];
   logic [IW-1:0] stack_b_ff [0:rarmt_pkg::STACK_DEPTH-1];
   logic          found_ff;
   logic [31:0]   acc_ff, child_add_ff;
   logic [rarmt_pkg::ROW_W-1:0] clr_ff;
   logic          rsp_valid_ff;
   logic [31:0]   rsp_data_ff;

   logic [rarmt_pkg::ROW_W-1:0]  row_a, row_b;
   logic [IW-1:0]  nm1_in, top_a, top_b, pmid;
   logic [IW:0]    mid_sum, pmid_sum;
   logic [rarmt_pkg::DEPTH_W-1:0] depth_m1;
   logic [31:0]   own_min, own_pend, node_val, new_min, child_add_in;
   logic [31:0]   comb_min;
   logic [63:0]   min_wr_row, pend_wr_row;
   logic          is_query, is_add, is_load, live;

   function automatic logic [31:0] smin(input logic [31:0] x, input logic [31:0] y);
      smin = ($signed(y) < $signed(x)) ? y : x;
   endfunction

   assign row_a    = node_ff[rarmt_pkg::NODE_W-1:1];
   assign row_b    = node_ff[rarmt_pkg::ROW_W-1:0];
   assign depth_m1 = depth_ff - 1'b1;
   assign top_a    = stack_a_ff[depth_m1];
   assign top_b    = stack_b_ff[depth_m1];
   assign mid_sum  = {1'b0, a_ff} + {1'b0, b_ff};
   assign pmid_sum = {1'b0, top_a} + {1'b0, top_b};
   assign pmid     = pmid_sum[IW:1];

   assign is_query = (mode_ff == rarmt_pkg::MODE_QUERY);
   assign is_add   = (mode_ff == rarmt_pkg::MODE_ADD);
   assign is_load  = (mode_ff == rarmt_pkg::MODE_LOAD);
   assign live     = (i_ff <= nm1_ff) && (i_ff <= j_ff) && (is_load || is_add || is_query);

   always_comb begin
      if (element_count == '0) begin
         nm1_in = '0;
      end else if (element_count > rarmt_pkg::COUNT_W'(rarmt_pkg::MAX_ELEMENTS)) begin
         nm1_in = IW'(rarmt_pkg::MAX_ELEMENTS - 1);
      end else begin
         nm1_in = IW'(element_count - 1'b1);
      end
   end

   // push: node takes its own pending add
   assign own_min  = node_ff[0] ? min_rd_a_ff[63:32]  : min_rd_a_ff[31:0];
   assign own_pend = node_ff[0] ? pend_rd_a_ff[63:32] : pend_rd_a_ff[31:0];
   assign node_val = own_min + own_pend;
   assign comb_min = smin(min_rd_b_ff[31:0], min_rd_b_ff[63:32]);

   always_comb begin
      new_min      = node_val;
      child_add_in = own_pend;
      if (!is_query && status.covered) begin
         if (is_load) begin
            new_min = value_ff;
         end else begin
            new_min      = node_val + value_ff;
            child_add_in = own_pend + value_ff;
         end
      end
   end

   always_comb begin
      min_wr_row  = min_rd_a_ff;
      pend_wr_row = pend_rd_a_ff;
      if (cmd.comb_write) begin
         if (node_ff[0]) min_wr_row[63:32] = comb_min;
         else            min_wr_row[31:0]  = comb_min;
      end else begin
         if (node_ff[0]) min_wr_row[63:32] = new_min;
         else            min_wr_row[31:0]  = new_min;
      end
      if (cmd.child_write) begin
         pend_wr_row = {pend_rd_b_ff[63:32] + child_add_ff,
                        pend_rd_b_ff[31:0]  + child_add_ff};
      end else if (node_ff[0]) begin
         pend_wr_row[63:32] = '0;
      end else begin
         pend_wr_row[31:0] = '0;
      end
   end

   // node stores
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         min_mem[clr_ff]  <= '0;
         pend_mem[clr_ff] <= '0;
      end else begin
         if (cmd.eval || cmd.comb_write) begin
            min_mem[row_a] <= min_wr_row;
         end
         if (cmd.eval) begin
            pend_mem[row_a] <= pend_wr_row;
         end else if (cmd.child_write) begin
            pend_mem[row_b] <= pend_wr_row;
         end
      end
      if (cmd.issue_read || cmd.comb_read) begin
         min_rd_a_ff  <= min_mem[row_a];
         min_rd_b_ff  <= min_mem[row_b];
         pend_rd_a_ff <= pend_mem[row_a];
         pend_rd_b_ff <= pend_mem[row_b];
      end
   end

   // traversal registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff  <= req_mode;
         i_ff     <= req_lo_index;
         j_ff     <= (req_mode == rarmt_pkg::MODE_LOAD) ? req_lo_index : req_hi_index;
         value_ff <= req_value;
         nm1_ff   <= nm1_in;
         node_ff  <= rarmt_pkg::NODE_W'(1);
         a_ff     <= '0;
         b_ff     <= nm1_in;
         depth_ff <= '0;
         found_ff <= 1'b0;
      end
      if (cmd.eval) begin
         child_add_ff <= child_add_in;
         if (is_query && status.covered) begin
            acc_ff   <= found_ff ? smin(acc_ff, node_val) : node_val;
            found_ff <= 1'b1;
         end
      end
      if (cmd.descend) begin
         stack_a_ff[depth_ff] <= a_ff;
         stack_b_ff[depth_ff] <= b_ff;
         node_ff  <= {node_ff[rarmt_pkg::NODE_W-2:0], 1'b0};
         b_ff     <= mid_sum[IW:1];
         depth_ff <= depth_ff + 1'b1;
      end
      if (cmd.ret_sibling) begin
         node_ff <= node_ff | rarmt_pkg::NODE_W'(1);
         a_ff    <= pmid + 1'b1;
         b_ff    <= top_b;
      end
      if (cmd.ret_pop) begin
         node_ff  <= node_ff >> 1;
         a_ff     <= top_a;
         b_ff     <= top_b;
         depth_ff <= depth_m1;
      end
   end

   // clearing sweep and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + 1'b1;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= found_ff ? acc_ff : rarmt_pkg::EMPTY_MINIMUM;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_range_minimum = rsp_data_ff;

   always_comb begin
      status.clear_done = (clr_ff == '1);
      status.live       = live;
      status.is_query   = is_query;
      status.disjoint   = (a_ff > j_ff) || (b_ff < i_ff);
      status.covered    = (a_ff >= i_ff) && (b_ff <= j_ff);
      status.internal   = (a_ff != b_ff);
      status.is_left    = ~node_ff[0];
      status.at_root    = (depth_ff == '0);
      status.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

endmodule

// File: rtl/core/rarmt_controller.sv
// ----------------------------------------------------------------------------
// rarmt_controller
// Sequencer for the depth-first walk: push, descend, return and combine.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rarmt_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rarmt_pkg::status_type  status,
   output rarmt_pkg::cmd_type     cmd
);

   rarmt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rarmt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         rarmt_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_done) state_in = rarmt_pkg::ST_IDLE;
         end
         rarmt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = rarmt_pkg::ST_CHECK;
            end
         end
         rarmt_pkg::ST_CHECK: begin
            if (status.live)         state_in = rarmt_pkg::ST_VISIT;
            else if (status.is_query) state_in = rarmt_pkg::ST_FINISH;
            else                      state_in = rarmt_pkg::ST_IDLE;
         end
         rarmt_pkg::ST_VISIT: begin
            // a query leaves disjoint nodes untouched
            if (status.is_query && status.disjoint) begin
               state_in = rarmt_pkg::ST_RETURN;
            end else begin
               cmd.issue_read = 1'b1;
               state_in       = rarmt_pkg::ST_EVAL;
            end
         end
         rarmt_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = status.internal ? rarmt_pkg::ST_CHILD : rarmt_pkg::ST_DECIDE;
         end
         rarmt_pkg::ST_CHILD: begin
            cmd.child_write = 1'b1;
            state_in        = rarmt_pkg::ST_DECIDE;
         end
         rarmt_pkg::ST_DECIDE: begin
            if (status.disjoint || status.covered) begin
               state_in = rarmt_pkg::ST_RETURN;
            end else begin
               cmd.descend = 1'b1;
               state_in    = rarmt_pkg::ST_VISIT;
            end
         end
         rarmt_pkg::ST_RETURN: begin
            if (status.at_root) begin
               state_in = rarmt_pkg::ST_FINISH;
            end else if (status.is_left) begin
               cmd.ret_sibling = 1'b1;
               state_in        = rarmt_pkg::ST_VISIT;
            end else begin
               cmd.ret_pop = 1'b1;
               state_in    = status.is_query ? rarmt_pkg::ST_RETURN : rarmt_pkg::ST_COMB_RD;
            end
         end
         rarmt_pkg::ST_COMB_RD: begin
            cmd.comb_read = 1'b1;
            state_in      = rarmt_pkg::ST_COMB_WR;
         end
         rarmt_pkg::ST_COMB_WR: begin
            cmd.comb_write = 1'b1;
            state_in       = rarmt_pkg::ST_RETURN;
         end
         rarmt_pkg::ST_FINISH: begin
            if (!status.is_query) begin
               state_in = rarmt_pkg::ST_IDLE;
            end else if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = rarmt_pkg::ST_IDLE;
            end
         end
         default: state_in = rarmt_pkg::ST_CLEAR;
      endcase
   end

   `RARMT_ASSERT(a_accept_then_busy, clock, reset, (req_valid && !req_stall) |=> req_stall, "beat accepted but stall dropped next cycle")
   `RARMT_NEVER(a_child_on_leaf, clock, reset, cmd.child_write && !status.internal, "pending handed down from a leaf")
   `RARMT_NEVER(a_rsp_overwrite, clock, reset, cmd.rsp_load && status.rsp_busy, "result overwritten while held")

endmodule

// File: rtl/core/range_add_range_min_tree.sv
// ----------------------------------------------------------------------------
// range_add_range_min_tree
// Lazy segment tree over up to 1024 signed 32-bit elements: load, range add
// and range minimum, with an element count register.
// ----------------------------------------------------------------------------
//  port group   direction  handshake            payload
//  req_*        in         req_valid/req_stall  mode, lo_index, hi_index, value
//  rsp_*        out        rsp_valid/rsp_stall  range_minimum
//  apb          in         psel/penable/pwrite  element_count at byte 0
//
//  One item at a time: each node is read, pushed, decided and returned, with
//  a child write when it hands its pending add down; a query returns from a
//  disjoint node unread, and loads and adds recombine each parent on return.
//  After reset every row of the node stores is zeroed; no beat is taken
//  meanwhile. A held result does not block the next item, only its delivery.
// ----------------------------------------------------------------------------
module range_add_range_min_tree (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_mode,
   input  logic [rarmt_pkg::INDEX_W-1:0]     req_lo_index,
   input  logic [rarmt_pkg::INDEX_W-1:0]     req_hi_index,
   input  logic signed [31:0]                req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_range_minimum,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [2:0]                        paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);

   logic [rarmt_pkg::COUNT_W-1:0] count_ff;
   rarmt_pkg::cmd_type    cmd;
   rarmt_pkg::status_type status;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= rarmt_pkg::COUNT_RESET;
      end else if (psel && penable && pwrite && (paddr[2] == rarmt_pkg::REG_ELEMENT_COUNT)) begin
         count_ff <= pwdata[rarmt_pkg::COUNT_W-1:0];
      end
   end

   assign prdata = (paddr[2] == rarmt_pkg::REG_ELEMENT_COUNT) ?
                   {{(32-rarmt_pkg::COUNT_W){1'b0}}, count_ff} : '0;

   rarmt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rarmt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .element_count     (count_ff),
      .req_mode          (req_mode),
      .req_lo_index      (req_lo_index),
      .req_hi_index      (req_hi_index),
      .req_value         (req_value),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_range_minimum (rsp_range_minimum)
   );

endmodule

// File: test/range_add_range_min_tree_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_range_min_tree_test
// Drives loads, range adds and range minimum queries into the lazy segment
// tree and checks every returned minimum against a behavioural model or a typed
// row value, across several element counts and with random gaps on both channels.
// ----------------------------------------------------------------------------
module range_add_range_min_tree_test;

   localparam logic [1:0] MODE_NONE  = 2'd3;
   localparam int         TREE_NODES = 2048;
   localparam int         DRAIN_CYCLES = 400;

   typedef struct {
      logic [1:0]         mode;
      logic [9:0]         lo;
      logic [9:0]         hi;
      logic signed [31:0] value;
      bit                 typed;
      logic signed [31:0] min_typed;
   } req_row_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_mode;
   logic [9:0]          req_lo_index;
   logic [9:0]          req_hi_index;
   logic signed [31:0]  req_value;
   logic                rsp_valid;
   logic                rsp_stall;
   logic signed [31:0]  rsp_range_minimum;
   logic                psel;
   logic                penable;
   logic                pwrite;
   logic [2:0]          paddr;
   logic [31:0]         pwdata;
   logic [31:0]         prdata;
   logic                pready;

   // model state
   logic signed [31:0]  node_min [TREE_NODES];
   logic signed [31:0]  node_pend [TREE_NODES];
   logic [10:0]         count_reg;

   logic signed [31:0]  minimum_q [$];
   int                  error_count;
   bit                  req_beat;
   bit                  cur_typed;
   logic signed [31:0]  cur_min_typed;
   int                  send_idle;
   int                  recv_idle;

   range_add_range_min_tree u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_lo_index(req_lo_index), .req_hi_index(req_hi_index),
      .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_range_minimum(rsp_range_minimum),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // ---------------------------------------------------------------- model
   function automatic int elements_used();
      int c;
      c = count_reg;
      if (c == 0) c = 1;
      if (c > rarmt_pkg::MAX_ELEMENTS) c = rarmt_pkg::MAX_ELEMENTS;
      return c;
   endfunction

   function automatic void push_down(int node, int a, int b);
      logic signed [31:0] p;
      p = node_pend[node];
      node_min[node] = node_min[node] + p;
      if (a != b && 2 * node + 1 < TREE_NODES) begin
         node_pend[2 * node]     = node_pend[2 * node] + p;
         node_pend[2 * node + 1] = node_pend[2 * node + 1] + p;
      end
      node_pend[node] = 0;
   endfunction

   function automatic void tree_update(int node, int a, int b, int i, int j,
                                       logic signed [31:0] v, bit set);
      int mid;
      if (node >= TREE_NODES) return;
      push_down(node, a, b);
      if (a > b || a > j || b < i) return;
      if (a >= i && b <= j) begin
         if (set) begin
            node_min[node] = v;
         end else begin
            node_min[node] = node_min[node] + v;
            if (a != b && 2 * node + 1 < TREE_NODES) begin
               node_pend[2 * node]     = node_pend[2 * node] + v;
               node_pend[2 * node + 1] = node_pend[2 * node + 1] + v;
            end
         end
         return;
      end
      if (2 * node + 1 >= TREE_NODES) return;
      mid = a + (b - a) / 2;
      tree_update(2 * node, a, mid, i, j, v, set);
      tree_update(2 * node + 1, mid + 1, b, i, j, v, set);
      node_min[node] = (node_min[2 * node + 1] < node_min[2 * node]) ?
                       node_min[2 * node + 1] : node_min[2 * node];
   endfunction

   function automatic logic signed [31:0] tree_min(int node, int a, int b,
                                                   int i, int j,
                                                   output bit found);
      int mid;
      bit f1, f2;
      logic signed [31:0] m1, m2;
      found = 1'b0;
      if (node >= TREE_NODES) return 0;
      if (a > b || a > j || b < i) return 0;
      push_down(node, a, b);
      if (a >= i && b <= j) begin
         found = 1'b1;
         return node_min[node];
      end
      if (2 * node + 1 >= TREE_NODES) return 0;
      mid = a + (b - a) / 2;
      m1 = tree_min(2 * node, a, mid, i, j, f1);
      m2 = tree_min(2 * node + 1, mid + 1, b, i, j, f2);
      found = f1 || f2;
      if (f1 && f2) return (m2 < m1) ? m2 : m1;
      return f1 ? m1 : m2;
   endfunction

   // returns 1 when the operation yields a minimum
   function automatic bit apply_op(logic [1:0] mode, int lo, int hi,
                                   logic signed [31:0] v,
                                   output logic signed [31:0] m);
      int n;
      bit found;
      n = elements_used();
      m = rarmt_pkg::EMPTY_MINIMUM;
      found = 1'b0;
      case (mode)
         rarmt_pkg::MODE_LOAD: begin
            if (lo < n) tree_update(1, 0, n - 1, lo, lo, v, 1'b1);
         end
         rarmt_pkg::MODE_ADD: begin
            if (lo <= hi && lo < n) tree_update(1, 0, n - 1, lo, hi, v, 1'b0);
         end
         rarmt_pkg::MODE_QUERY: begin
            if (lo <= hi && lo < n) m = tree_min(1, 0, n - 1, lo, hi, found);
            if (!found) m = rarmt_pkg::EMPTY_MINIMUM;
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // ------------------------------------------------------ monitor / check
   always @(posedge clock) begin
      logic signed [31:0] m;
      logic signed [31:0] want;
      req_beat = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (minimum_q.size() == 0) begin
               $error("unexpected beat: range_minimum %0d", rsp_range_minimum);
               error_count++;
            end else begin
               want = minimum_q.pop_front();
               if (rsp_range_minimum !== want) begin
                  $error("range_minimum: expected %0d, actual %0d", want,
                         rsp_range_minimum);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_beat = 1'b1;
            if (apply_op(req_mode, req_lo_index, req_hi_index, req_value, m))
               minimum_q.push_back(cur_typed ? cur_min_typed : m);
         end
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
   end

   // ------------------------------------------------------------- drivers
   task automatic send_req(req_row_type r);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_mode      <= r.mode;
      req_lo_index  <= r.lo;
      req_hi_index  <= r.hi;
      req_value     <= r.value;
      cur_typed     <= r.typed;
      cur_min_typed <= r.min_typed;
      do @(negedge clock); while (!req_beat);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (minimum_q.size() != 0) @(negedge clock);
      // loads and adds leave no beat behind, so give the tree time to finish
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(logic [10:0] c);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= 3'(4 * rarmt_pkg::REG_ELEMENT_COUNT);
      pwdata  <= {$urandom_range(0, 1) ? 21'h1fffff : 21'h0, c};
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      count_reg = c;
   endtask

   function automatic req_row_type random_req();
      req_row_type r;
      int n;
      int pick;
      n = elements_used();
      pick = $urandom_range(99);
      r.mode = (pick < 30) ? rarmt_pkg::MODE_LOAD : (pick < 60) ? rarmt_pkg::MODE_ADD :
               (pick < 97) ? rarmt_pkg::MODE_QUERY : MODE_NONE;
      r.lo = ($urandom_range(99) < 75) ? 10'($urandom_range(0, n - 1)) :
                                         10'($urandom);
      if ($urandom_range(99) < 65)
         r.hi = 10'($urandom_range(r.lo, (r.lo + 40 > 1023) ? 1023 : r.lo + 40));
      else
         r.hi = 10'($urandom);
      pick = $urandom_range(9);
      case (pick)
         0:       r.value = 32'sh8000_0000;
         1:       r.value = 32'sh7fff_ffff;
         2:       r.value = 32'sd2100000000 + $signed(32'($urandom_range(0, 4))) - 2;
         3, 4, 5: r.value = $signed(32'($urandom_range(0, 400))) - 200;
         default: r.value = $signed($urandom);
      endcase
      r.typed = 1'b0;
      r.min_typed = 0;
      return r;
   endfunction

   // -------------------------------------------------------------- stimulus
   initial begin
      req_row_type dir_rows [$];
      logic [10:0] counts [12];
      int k;

      counts = '{11'd1024, 11'd0, 11'd2047, 11'd1, 11'd2, 11'd16,
                 11'd37, 11'd600, 11'd1000, 11'd5, 11'd513, 11'd1024};
      reset = 1'b1;
      req_valid = 1'b0; req_mode = rarmt_pkg::MODE_LOAD; req_lo_index = '0;
      req_hi_index = '0; req_value = '0; rsp_stall = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      cur_typed = 1'b0; cur_min_typed = 0; error_count = 0;
      count_reg = rarmt_pkg::COUNT_RESET;
      for (k = 0; k < TREE_NODES; k++) begin
         node_min[k]  = 0;
         node_pend[k] = 0;
      end
      send_idle = 36;
      recv_idle = 46;

      dir_rows = '{
         '{rarmt_pkg::MODE_QUERY, 10'd0,    10'd1023, 32'sd0,          1, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd9,    10'd3,    32'sd0,          1,
           rarmt_pkg::EMPTY_MINIMUM},
         '{rarmt_pkg::MODE_LOAD,  10'd0,    10'd0,    32'sh8000_0000,  0, 32'sd0},
         '{rarmt_pkg::MODE_LOAD,  10'd1023, 10'd0,    32'sh7fff_ffff,  0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd0,    10'd0,    32'sd0,          1, 32'sh8000_0000},
         '{rarmt_pkg::MODE_QUERY, 10'd1023, 10'd1023, 32'sd0,          1, 32'sh7fff_ffff},
         '{rarmt_pkg::MODE_QUERY, 10'd0,    10'd1023, 32'sd0,          1, 32'sh8000_0000},
         '{rarmt_pkg::MODE_ADD,   10'd0,    10'd1023, 32'sd1,          0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd1000, 10'd1023, 32'sd0,          0, 32'sd0},
         '{rarmt_pkg::MODE_ADD,   10'd1020, 10'd1023, 32'sh7fff_ffff,  0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd1019, 10'd1023, 32'sd0,          0, 32'sd0},
         '{rarmt_pkg::MODE_ADD,   10'd50,   10'd10,   32'sd99,         0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd10,   10'd50,   32'sd0,          0, 32'sd0},
         '{rarmt_pkg::MODE_LOAD,  10'd5,    10'd0,    32'sd2100000000, 0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd5,    10'd5,    32'sd0,          1, 32'sd2100000000},
         '{MODE_NONE,             10'd7,    10'd700,  32'sd5,          0, 32'sd0},
         '{rarmt_pkg::MODE_ADD,   10'd3,    10'd700,  -32'sd77,        0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd1,    10'd900,  32'sd0,          0, 32'sd0},
         '{rarmt_pkg::MODE_QUERY, 10'd512,  10'd512,  32'sd0,          0, 32'sd0}
      };

      repeat (12) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_req(dir_rows[i]);

      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 36 : (ph == 1) ? 46 : 0;
         recv_idle = (ph == 0) ? 46 : (ph == 1) ? 36 : 0;
         for (int c = 0; c < 4; c++) begin
            settle();
            write_count(counts[ph * 4 + c]);
            for (int j = 0; j < 120; j++) send_req(random_req());
         end
      end

      settle();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/rarmt_pkg.sv
rtl/core/rarmt_datapath.sv
rtl/core/rarmt_controller.sv
rtl/core/range_add_range_min_tree.sv
test/range_add_range_min_tree_test.sv
